/* hw/rtl/dri_pkg.sv */
// Shared constants, types and the arctangent table of the delta robot
// inverse kinematics core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dri_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STEPS    = 20;
  localparam int ACC_FRAC        = 24;
  localparam int PROD_DROP       = 8;
  localparam int TRIG_FRAC       = 16;
  localparam int SIN120_Q16      = 56756;

  localparam int SQRT_STEPS = 30;
  localparam int DISC_W     = 2 * SQRT_STEPS;
  localparam int LNM_W      = 32;
  localparam int CW         = 36;
  localparam int AW         = 36;
  localparam int ANG_W      = 18;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_RADIUS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_ARM_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_ARM_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOW_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_HIGH_LIMIT = 3'd4;

  typedef struct packed {
    logic                    valid;
    logic signed [LNM_W-1:0] lv;
    logic signed [LNM_W-1:0] nv;
    logic signed [LNM_W-1:0] mv;
  } arm_in_t;

  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic signed [ANG_W-1:0] angle;
  } arm_res_t;

  // atan(2^-i) in degrees, Q24
  function automatic logic signed [AW-1:0] atan_q24(input int idx);
    logic signed [AW-1:0] v;
    case (idx)
      0:  v = AW'(754974720);
      1:  v = AW'(445687602);
      2:  v = AW'(235489088);
      3:  v = AW'(119537938);
      4:  v = AW'(60000934);
      5:  v = AW'(30029717);
      6:  v = AW'(15018523);
      7:  v = AW'(7509720);
      8:  v = AW'(3754917);
      9:  v = AW'(1877466);
      10: v = AW'(938734);
      11: v = AW'(469367);
      12: v = AW'(234684);
      13: v = AW'(117342);
      14: v = AW'(58671);
      15: v = AW'(29335);
      16: v = AW'(14668);
      17: v = AW'(7334);
      18: v = AW'(3667);
      19: v = AW'(1833);
      20: v = AW'(917);
      21: v = AW'(458);
      22: v = AW'(229);
      23: v = AW'(115);
      24: v = AW'(57);
      25: v = AW'(29);
      26: v = AW'(14);
      27: v = AW'(7);
      28: v = AW'(4);
      29: v = AW'(2);
      30: v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/delta_robot_inverse_kinematics_core.sv */
// Delta robot inverse kinematics: products and per-arm l, m, n terms,
// three dri_arm pipelines and the flag/output register. Depends on dri_pkg.
// One item per cycle while the result is not stalled.
// A stalled result freezes the whole pipeline in place; nothing is lost.
// Reset clears all valid bits and loads the default arm geometry and limits.
`timescale 1ns / 1ps
`default_nettype none

module delta_robot_inverse_kinematics_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [17:0]                in_target_x,
  input  wire logic signed [17:0]                in_target_y,
  input  wire logic signed [17:0]                in_target_z,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [17:0]                     out_angle_arm0,
  output logic signed [17:0]                     out_angle_arm1,
  output logic signed [17:0]                     out_angle_arm2,
  output logic                                   out_outside_workspace,
  output logic                                   out_angle_out_of_range,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dri_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dri_pkg::CFG_W-1:0]         cfg_data
);

  localparam int PW  = 36;
  localparam int BSW = 39;
  localparam int SW  = 54;
  localparam int WW  = 58;
  localparam int LW  = dri_pkg::LNM_W;
  localparam int TF  = dri_pkg::TRIG_FRAC;
  localparam int DROP = dri_pkg::TRIG_FRAC + dri_pkg::PROD_DROP;
  localparam logic signed [17:0] SIN120 = 18'(dri_pkg::SIN120_Q16);

  // configuration
  logic [dri_pkg::CFG_W-1:0]        base_radius_r, upper_len_r, lower_len_r;
  logic signed [dri_pkg::CFG_W-1:0] low_lim_r, high_lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_radius_r <= 17'd8520;
      upper_len_r   <= 17'd17695;
      lower_len_r   <= 17'd48497;
      low_lim_r     <= -17'sd15360;
      high_lim_r    <= 17'sd23040;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dri_pkg::CFG_BASE_RADIUS:      base_radius_r <= cfg_data;
        dri_pkg::CFG_UPPER_ARM_LENGTH: upper_len_r   <= cfg_data;
        dri_pkg::CFG_LOWER_ARM_LENGTH: lower_len_r   <= cfg_data;
        dri_pkg::CFG_ANGLE_LOW_LIMIT:  low_lim_r     <= $signed(cfg_data);
        dri_pkg::CFG_ANGLE_HIGH_LIMIT: high_lim_r    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic signed [17:0] r_s, la_s, lb_s;
  assign r_s  = $signed({1'b0, base_radius_r});
  assign la_s = $signed({1'b0, upper_len_r});
  assign lb_s = $signed({1'b0, lower_len_r});

  // stage 1: raw products
  logic                 p1_v_r;
  logic signed [PW-1:0] p1_xx_r, p1_yy_r, p1_zz_r, p1_ll_r, p1_bb_r, p1_rr_r;
  logic signed [PW-1:0] p1_xl_r, p1_yl_r, p1_xr_r, p1_yr_r, p1_zl_r, p1_rl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_xx_r <= in_target_x * in_target_x;
      p1_yy_r <= in_target_y * in_target_y;
      p1_zz_r <= in_target_z * in_target_z;
      p1_ll_r <= la_s * la_s;
      p1_bb_r <= lb_s * lb_s;
      p1_rr_r <= r_s * r_s;
      p1_xl_r <= in_target_x * la_s;
      p1_yl_r <= in_target_y * la_s;
      p1_xr_r <= in_target_x * r_s;
      p1_yr_r <= in_target_y * r_s;
      p1_zl_r <= in_target_z * la_s;
      p1_rl_r <= r_s * la_s;
    end
  end

  // stage 2: common sum and sin 120 scaling
  logic                  p2_v_r;
  logic signed [BSW-1:0] p2_base_r;
  logic signed [SW-1:0]  p2_yls_r, p2_yrs_r;
  logic signed [PW-1:0]  p2_xl_r, p2_xr_r, p2_zl_r, p2_rl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_base_r <= BSW'(p1_xx_r) + BSW'(p1_yy_r) + BSW'(p1_zz_r)
                 + BSW'(p1_ll_r) - BSW'(p1_bb_r) + BSW'(p1_rr_r);
      p2_yls_r  <= p1_yl_r * SIN120;
      p2_yrs_r  <= p1_yr_r * SIN120;
      p2_xl_r   <= p1_xl_r;
      p2_xr_r   <= p1_xr_r;
      p2_zl_r   <= p1_zl_r;
      p2_rl_r   <= p1_rl_r;
    end
  end

  // stage 3: l and n per arm, m shared
  logic signed [WW-1:0] rl17, xl17, xl16, yls1, base16, xr17, xr16, yrs1;
  logic signed [WW-1:0] lw [0:2];
  logic signed [WW-1:0] nw [0:2];

  always_comb begin
    rl17   = WW'(p2_rl_r) <<< (TF + 1);
    xl17   = WW'(p2_xl_r) <<< (TF + 1);
    xl16   = WW'(p2_xl_r) <<< TF;
    yls1   = WW'(p2_yls_r) <<< 1;
    base16 = WW'(p2_base_r) <<< TF;
    xr17   = WW'(p2_xr_r) <<< (TF + 1);
    xr16   = WW'(p2_xr_r) <<< TF;
    yrs1   = WW'(p2_yrs_r) <<< 1;
    lw[0]  = rl17 - xl17;
    lw[1]  = rl17 + xl16 + yls1;
    lw[2]  = rl17 + xl16 - yls1;
    nw[0]  = base16 - xr17;
    nw[1]  = base16 + yrs1 + xr16;
    nw[2]  = base16 - yrs1 + xr16;
  end

  logic                 p3_v_r;
  logic signed [LW-1:0] p3_lv_r [0:2];
  logic signed [LW-1:0] p3_nv_r [0:2];
  logic signed [LW-1:0] p3_mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p3_lv_r[k] <= LW'(lw[k] >>> DROP);
        p3_nv_r[k] <= LW'(nw[k] >>> DROP);
      end
      // 2*z*la floor-shifted by the product drop
      p3_mv_r <= LW'(p2_zl_r >>> (dri_pkg::PROD_DROP - 1));
    end
  end

  dri_pkg::arm_in_t  arm_in  [0:2];
  dri_pkg::arm_res_t arm_res [0:2];

  for (genvar k = 0; k < 3; k++) begin : g_arm
    assign arm_in[k].valid = p3_v_r;
    assign arm_in[k].lv    = p3_lv_r[k];
    assign arm_in[k].nv    = p3_nv_r[k];
    assign arm_in[k].mv    = p3_mv_r;

    dri_arm u_arm (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .arm_i (arm_in[k]),
      .res_o (arm_res[k])
    );
  end

  // flags and output register
  logic outside, range_hit;
  assign outside = arm_res[0].neg || arm_res[1].neg || arm_res[2].neg;

  always_comb begin
    range_hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (arm_res[k].angle < low_lim_r || arm_res[k].angle > high_lim_r) begin
        range_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= arm_res[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_outside_workspace  <= outside;
      out_angle_out_of_range <= !outside && range_hit;
      out_angle_arm0         <= outside ? '0 : arm_res[0].angle;
      out_angle_arm1         <= outside ? '0 : arm_res[1].angle;
      out_angle_arm2         <= outside ? '0 : arm_res[2].angle;
    end
  end

  a_outside_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside_workspace |->
      out_angle_arm0 == '0 && out_angle_arm1 == '0 && out_angle_arm2 == '0)
    else $error("angles not cleared outside the workspace");

  a_flags_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_outside_workspace && out_angle_out_of_range))
    else $error("range flag raised with workspace flag");

  a_arms_aligned : assert property (@(posedge clk) disable iff (!rst_n)
    arm_res[0].valid == arm_res[1].valid && arm_res[0].valid == arm_res[2].valid)
    else $error("arm pipelines out of step");

endmodule

`default_nettype wire

/* hw/rtl/dri_arm.sv */
// One arm of the inverse kinematics pipeline: squares, discriminant,
// bit-serial pipelined square root, vectoring CORDIC and angle wrap.
// Depends on dri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dri_arm (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire dri_pkg::arm_in_t   arm_i,
  output dri_pkg::arm_res_t       res_o
);

  localparam int NS  = dri_pkg::SQRT_STEPS;
  localparam int DW  = dri_pkg::DISC_W;
  localparam int NC  = dri_pkg::CORDIC_STEPS;
  localparam int CW  = dri_pkg::CW;
  localparam int AW  = dri_pkg::AW;
  localparam int LW  = dri_pkg::LNM_W;
  localparam int BW  = LW + 1;
  localparam int QW  = LW + 2;
  localparam int PW  = 2 * LW;
  localparam int AFW = dri_pkg::ANG_W + 1;
  localparam int SH  = dri_pkg::ACC_FRAC - dri_pkg::ANGLE_FRAC_BITS;

  localparam logic signed [AW-1:0]  ACC_90  = AW'(90) <<< dri_pkg::ACC_FRAC;
  localparam logic signed [AW:0]    RND_W   = (AW + 1)'(1) <<< (SH - 1);
  localparam logic signed [AFW-1:0] DEG90   = AFW'(90) <<< dri_pkg::ANGLE_FRAC_BITS;
  localparam logic signed [AFW-1:0] DEG360  = AFW'(360) <<< dri_pkg::ANGLE_FRAC_BITS;

  // squares
  logic                 a1_v_r;
  logic signed [PW-1:0] a1_mm_r, a1_ll_r, a1_nn_r;
  logic signed [BW-1:0] a1_mneg_r, a1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_v_r <= 1'b0;
    end else if (en) begin
      a1_v_r <= arm_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_mm_r   <= arm_i.mv * arm_i.mv;
      a1_ll_r   <= arm_i.lv * arm_i.lv;
      a1_nn_r   <= arm_i.nv * arm_i.nv;
      a1_mneg_r <= -BW'(arm_i.mv);
      a1_b_r    <= BW'(arm_i.nv) - BW'(arm_i.lv);
    end
  end

  // discriminant and square root pipeline
  logic signed [PW-1:0] disc;
  assign disc = a1_mm_r + a1_ll_r - a1_nn_r;

  logic                 sq_v_r    [0:NS];
  logic                 sq_neg_r  [0:NS];
  logic [DW-1:0]        sq_rem_r  [0:NS-1];
  logic [DW-1:0]        sq_root_r [0:NS];
  logic signed [BW-1:0] sq_mneg_r [0:NS];
  logic signed [BW-1:0] sq_b_r    [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= a1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_neg_r[0]  <= disc[PW-1];
      sq_rem_r[0]  <= disc[DW-1:0];
      sq_root_r[0] <= '0;
      sq_mneg_r[0] <= a1_mneg_r;
      sq_b_r[0]    <= a1_b_r;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam logic [DW:0] BITV = (DW + 1)'(1) << (2 * (NS - 1 - j));
    logic [DW:0] trial;
    logic        take;
    assign trial = {1'b0, sq_root_r[j]} + BITV;
    assign take  = {1'b0, sq_rem_r[j]} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_neg_r[j+1]  <= sq_neg_r[j];
        sq_mneg_r[j+1] <= sq_mneg_r[j];
        sq_b_r[j+1]    <= sq_b_r[j];
        if (take) begin
          sq_root_r[j+1] <= (sq_root_r[j] >> 1) + BITV[DW-1:0];
        end else begin
          sq_root_r[j+1] <= sq_root_r[j] >> 1;
        end
      end
    end

    if (j < NS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          if (take) begin
            sq_rem_r[j+1] <= sq_rem_r[j] - trial[DW-1:0];
          end else begin
            sq_rem_r[j+1] <= sq_rem_r[j];
          end
        end
      end
    end
  end

  // atan2 operands
  logic                 q_v_r, q_neg_r;
  logic signed [QW-1:0] q_a_r;
  logic signed [BW-1:0] q_b_r;
  logic signed [QW-1:0] sq_ext;
  assign sq_ext = $signed({{(QW - NS){1'b0}}, sq_root_r[NS][NS-1:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (en) begin
      q_v_r <= sq_v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_neg_r <= sq_neg_r[NS];
      q_a_r   <= QW'(sq_mneg_r[NS]) - sq_ext;
      q_b_r   <= sq_b_r[NS];
    end
  end

  // quadrant pre-rotation, then CORDIC stages
  logic                 cx_v_r    [0:NC];
  logic                 cx_neg_r  [0:NC];
  logic                 cx_zero_r [0:NC];
  logic signed [CW-1:0] cx_x_r    [0:NC-1];
  logic signed [CW-1:0] cx_y_r    [0:NC-1];
  logic signed [AW-1:0] cx_acc_r  [0:NC];

  logic signed [CW-1:0] pa, pb;
  assign pa = CW'(q_a_r);
  assign pb = CW'(q_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_v_r[0] <= 1'b0;
    end else if (en) begin
      cx_v_r[0] <= q_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_neg_r[0]  <= q_neg_r;
      cx_zero_r[0] <= (q_a_r == '0) && (q_b_r == '0);
      if (q_b_r < 0) begin
        if (q_a_r >= 0) begin
          cx_x_r[0]   <= pa;
          cx_y_r[0]   <= -pb;
          cx_acc_r[0] <= ACC_90;
        end else begin
          cx_x_r[0]   <= -pa;
          cx_y_r[0]   <= pb;
          cx_acc_r[0] <= -ACC_90;
        end
      end else begin
        cx_x_r[0]   <= pb;
        cx_y_r[0]   <= pa;
        cx_acc_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam logic signed [AW-1:0] ATAN = dri_pkg::atan_q24(i);
    logic signed [CW-1:0] dx, dy;
    logic                 up;
    assign dx = cx_y_r[i] >>> i;
    assign dy = cx_x_r[i] >>> i;
    assign up = !cx_y_r[i][CW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cx_v_r[i+1] <= 1'b0;
      end else if (en) begin
        cx_v_r[i+1] <= cx_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_neg_r[i+1]  <= cx_neg_r[i];
        cx_zero_r[i+1] <= cx_zero_r[i];
        cx_acc_r[i+1]  <= up ? cx_acc_r[i] + ATAN : cx_acc_r[i] - ATAN;
      end
    end

    if (i < NC - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          cx_x_r[i+1] <= up ? cx_x_r[i] + dx : cx_x_r[i] - dx;
          cx_y_r[i+1] <= up ? cx_y_r[i] - dy : cx_y_r[i] + dy;
        end
      end
    end
  end

  // double, round, wrap into the range around zero
  logic signed [AW-1:0]  acc_f;
  logic signed [AW:0]    a2_w;
  logic signed [AFW-1:0] a2, a2_wrap;

  always_comb begin
    acc_f = cx_zero_r[NC] ? '0 : cx_acc_r[NC];
    a2_w  = (((AW + 1)'(acc_f)) <<< 1) + RND_W;
    a2_w  = a2_w >>> SH;
    a2    = AFW'(a2_w);
    if (a2 < -DEG90) begin
      a2_wrap = a2 + DEG360;
    end else if (a2 > DEG90) begin
      a2_wrap = a2 - DEG360;
    end else begin
      a2_wrap = a2;
    end
  end

  logic                              f_v_r, f_neg_r;
  logic signed [dri_pkg::ANG_W-1:0] f_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= cx_v_r[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_neg_r <= cx_neg_r[NC];
      f_ang_r <= cx_neg_r[NC] ? '0 : dri_pkg::ANG_W'(a2_wrap);
    end
  end

  assign res_o.valid = f_v_r;
  assign res_o.neg   = f_neg_r;
  assign res_o.angle = f_ang_r;

endmodule

`default_nettype wire

/* test/delta_robot_inverse_kinematics_core_test.sv */
// Testbench for delta_robot_inverse_kinematics_core: random and directed targets,
// a fixed-point predictor of the three arm angles, and randomized idling on both sides.
// Depends on dri_pkg and the core RTL.
`timescale 1ns / 1ps

module delta_robot_inverse_kinematics_core_test;

  typedef struct packed {
    logic signed [17:0] arm0;
    logic signed [17:0] arm1;
    logic signed [17:0] arm2;
    logic               outside;
    logic               out_of_range;
  } arm_angles_t;

  // Predicts arm angles for each accepted target and checks results in order.
  class arm_angle_book;
    longint      radius, upper_len, lower_len, low_lim, high_lim;
    arm_angles_t pending_angles[$];
    int          fail_count;

    function new();
      radius = 8520; upper_len = 17695; lower_len = 48497;
      low_lim = -15360; high_lim = 23040;
      fail_count = 0;
    endfunction

    function void write_reg(logic [dri_pkg::CFG_IDX_W-1:0] idx,
                            logic [dri_pkg::CFG_W-1:0] data);
      case (idx)
        dri_pkg::CFG_BASE_RADIUS:      radius = longint'(data);
        dri_pkg::CFG_UPPER_ARM_LENGTH: upper_len = longint'(data);
        dri_pkg::CFG_LOWER_ARM_LENGTH: lower_len = longint'(data);
        dri_pkg::CFG_ANGLE_LOW_LIMIT:  low_lim = longint'(signed'(data));
        dri_pkg::CFG_ANGLE_HIGH_LIMIT: high_lim = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    function longint floor_sqrt(longint v);
      longint unsigned rem, root, b;
      rem = v; root = 0; b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem = rem - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return longint'(root);
    endfunction

    // atan2(a, b) in degrees, Q24
    function longint atan2_deg(longint a, longint b);
      longint xv, yv, acc, t, dx, dy;
      xv = b; yv = a; acc = 0;
      if (a == 0 && b == 0) return 0;
      if (xv < 0) begin
        t = xv;
        if (yv >= 0) begin
          xv = yv; yv = -t; acc = 64'sd90 <<< 24;
        end else begin
          xv = -yv; yv = t; acc = -(64'sd90 <<< 24);
        end
      end
      for (int i = 0; i < dri_pkg::CORDIC_STEPS; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv >= 0) begin
          xv += dx; yv -= dy; acc += longint'(dri_pkg::atan_q24(i));
        end else begin
          xv -= dx; yv += dy; acc -= longint'(dri_pkg::atan_q24(i));
        end
      end
      return acc;
    endfunction

    function void note_target(logic signed [17:0] tx, logic signed [17:0] ty,
                              logic signed [17:0] tz);
      longint x, y, z, cosq[3], sinq[3], ang[3];
      longint base, lw, nw, lv, nv, mv, disc, sq, a2;
      logic outside, rng;
      arm_angles_t e;
      x = tx; y = ty; z = tz;
      cosq = '{65536, -32768, -32768};
      sinq = '{0, dri_pkg::SIN120_Q16, -dri_pkg::SIN120_Q16};
      outside = 0; rng = 0;
      for (int k = 0; k < 3; k++) begin
        base = x*x + y*y + z*z + upper_len*upper_len - lower_len*lower_len + radius*radius;
        lw = 2*radius*upper_len*65536 - 2*(x*upper_len)*cosq[k] + 2*(y*upper_len)*sinq[k];
        nw = base*65536 + 2*(y*radius)*sinq[k] - 2*(x*radius)*cosq[k];
        lv = lw >>> 24;
        nv = nw >>> 24;
        mv = (2*z*upper_len) >>> dri_pkg::PROD_DROP;
        disc = mv*mv + lv*lv - nv*nv;
        ang[k] = 0;
        if (disc < 0) begin
          outside = 1;
        end else begin
          sq = floor_sqrt(disc);
          a2 = (2*atan2_deg(-mv - sq, nv - lv) + (64'sd1 <<< 15)) >>> 16;
          if (a2 < -23040) a2 += 92160;
          else if (a2 > 23040) a2 -= 92160;
          ang[k] = a2;
        end
      end
      if (outside) begin
        ang = '{0, 0, 0};
      end else begin
        for (int k = 0; k < 3; k++)
          if (ang[k] < low_lim || ang[k] > high_lim) rng = 1;
      end
      e.arm0 = ang[0][17:0]; e.arm1 = ang[1][17:0]; e.arm2 = ang[2][17:0];
      e.outside = outside; e.out_of_range = rng;
      pending_angles.push_back(e);
    endfunction

    function void check_angles(arm_angles_t got);
      arm_angles_t e;
      if (pending_angles.size() == 0) begin
        $error("result with no target pending");
        fail_count++;
        return;
      end
      e = pending_angles.pop_front();
      if (got.arm0 !== e.arm0) begin
        $error("angle_arm0 expected %0d got %0d", e.arm0, got.arm0); fail_count++;
      end
      if (got.arm1 !== e.arm1) begin
        $error("angle_arm1 expected %0d got %0d", e.arm1, got.arm1); fail_count++;
      end
      if (got.arm2 !== e.arm2) begin
        $error("angle_arm2 expected %0d got %0d", e.arm2, got.arm2); fail_count++;
      end
      if (got.outside !== e.outside) begin
        $error("outside_workspace expected %0d got %0d", e.outside, got.outside);
        fail_count++;
      end
      if (got.out_of_range !== e.out_of_range) begin
        $error("angle_out_of_range expected %0d got %0d", e.out_of_range,
               got.out_of_range);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [17:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [17:0] out_angle_arm0, out_angle_arm1, out_angle_arm2;
  logic out_outside_workspace, out_angle_out_of_range;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [dri_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dri_pkg::CFG_W-1:0] cfg_data = '0;

  arm_angle_book book = new();
  int send_idle_pct = 29;
  int recv_stall_pct = 29;
  int quiet_cycles = 0;
  localparam int QUIET_LIMIT = 3000;

  delta_robot_inverse_kinematics_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_target_x(in_target_x), .in_target_y(in_target_y), .in_target_z(in_target_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_angle_arm0(out_angle_arm0), .out_angle_arm1(out_angle_arm1),
    .out_angle_arm2(out_angle_arm2),
    .out_outside_workspace(out_outside_workspace),
    .out_angle_out_of_range(out_angle_out_of_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.check_angles({out_angle_arm0, out_angle_arm1, out_angle_arm2,
                         out_outside_workspace, out_angle_out_of_range});
  end

  // Count cycles with no handshake of any kind.
  always @(posedge clk) begin
    if (!rst_n || (out_valid && !out_stall) || (in_valid && !in_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_target(logic signed [17:0] x, logic signed [17:0] y,
                             logic signed [17:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_target_x <= x; in_target_y <= y; in_target_z <= z;
    do @(posedge clk); while (in_stall);
    book.note_target(x, y, z);
  endtask

  task automatic write_reg(logic [dri_pkg::CFG_IDX_W-1:0] idx,
                           logic [dri_pkg::CFG_W-1:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    book.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Hold the sender until every pending angle set has come back.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (book.pending_angles.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_geometry(int r, int la, int lb, int lo, int hi);
    write_reg(dri_pkg::CFG_BASE_RADIUS, dri_pkg::CFG_W'(r));
    write_reg(dri_pkg::CFG_UPPER_ARM_LENGTH, dri_pkg::CFG_W'(la));
    write_reg(dri_pkg::CFG_LOWER_ARM_LENGTH, dri_pkg::CFG_W'(lb));
    write_reg(dri_pkg::CFG_ANGLE_LOW_LIMIT, dri_pkg::CFG_W'(lo));
    write_reg(dri_pkg::CFG_ANGLE_HIGH_LIMIT, dri_pkg::CFG_W'(hi));
  endtask

  // Mostly reachable targets under the arm; the rest anywhere.
  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75)
        send_target(18'($signed($urandom_range(39320)) - 19660),
                    18'($signed($urandom_range(39320)) - 19660),
                    18'(-$signed($urandom_range(58982, 19660))));
      else
        send_target(18'($urandom), 18'($urandom), 18'($urandom));
    end
  endtask

  initial begin
    logic signed [17:0] mx, mn;
    mx = 18'sh1FFFF; mn = 18'sh20000;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes, origin, reachable poses.
    send_target(0, 0, 0);
    send_target(mx, mx, mx);
    send_target(mn, mn, mn);
    send_target(mx, mn, 0);
    send_target(mn, mx, mn);
    send_target(0, 0, mx);
    send_target(0, 0, mn);
    send_target(0, 0, -18'sd45875);
    send_target(0, 0, -18'sd32768);
    send_target(13107, 0, -18'sd45875);
    send_target(-13107, 0, -18'sd45875);
    send_target(0, 13107, -18'sd39321);
    send_target(0, -13107, -18'sd52428);
    send_target(19660, 19660, -18'sd58982);
    send_target(-19660, -19660, -18'sd26214);
    send_target(1, -1, -18'sd1);
    send_target(-1, 1, -18'sd50000);
    send_random(200);
    drain();

    // Zero vector: no radius and equal arm lengths at the origin.
    set_geometry(0, 17695, 17695, -46080, 46080);
    send_target(0, 0, 0);
    send_target(1, 0, 0);
    send_random(20);
    drain();

    // Largest geometry, widest limits; an unknown index must be ignored.
    set_geometry(131071, 131071, 131071, -46080, 46080);
    write_reg(dri_pkg::CFG_ANGLE_HIGH_LIMIT + 3'd1
                + dri_pkg::CFG_IDX_W'($urandom_range(2)),
              dri_pkg::CFG_W'($urandom));
    send_target(mx, mx, mx);
    send_target(mn, mn, mn);
    send_random(80);
    drain();

    // Zero geometry and crossed limits.
    set_geometry(0, 0, 0, 23040, -15360);
    send_random(40);
    drain();
    set_geometry(8520, 17695, 48497, 23040, -15360);
    send_random(60);
    drain();

    for (int p = 0; p < 3; p++) begin
      set_geometry($urandom_range(131071), $urandom_range(131071),
                   $urandom_range(131071), $signed($urandom_range(92160)) - 46080,
                   $signed($urandom_range(92160)) - 46080);
      send_random(40);
      drain();
    end

    // Defaults again with a long stretch of no idling on either side.
    set_geometry(8520, 17695, 48497, -15360, 23040);
    send_idle_pct = 0; recv_stall_pct = 0;
    send_random(120);
    send_idle_pct = 29; recv_stall_pct = 29;
    send_random(100);
    in_valid <= 0;
    @(posedge clk);
    while (book.pending_angles.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (book.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
